// File: hw/rtl/rvs_pkg.sv
// Shared types and codes for the register value store.
package rvs_pkg;

	// Operation codes carried on the request tuser
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	// Field widths
	localparam int DEV_W   = 16;
	localparam int REG_W   = 8;
	localparam int VAL_W   = 16;
	localparam int COUNT_W = 5;

	// One stored entry: key and value
	typedef struct packed {
		logic [DEV_W-1:0] dev_id;
		logic [REG_W-1:0] reg_id;
		logic [VAL_W-1:0] value;
	} rvs_entry_t;

endpackage

// File: hw/rtl/rvs_store.sv
// Entry memory: one write port, one registered read port.
module rvs_store
	import rvs_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  rvs_entry_t        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output rvs_entry_t        rdata
);

	rvs_entry_t mem [TABLE_ENTRIES];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry, hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/rvs_ctrl.sv
// Request sequencer: scans stored entries through one key comparator, then writes the entry for a write request.
module rvs_ctrl
	import rvs_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_op,
	input  logic [DEV_W-1:0]   in_dev,
	input  logic [REG_W-1:0]   in_reg,
	input  logic [VAL_W-1:0]   in_val,
	// result side
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic [DEV_W-1:0]   out_dev,
	output logic [REG_W-1:0]   out_reg,
	output logic [VAL_W-1:0]   out_val,
	output logic [COUNT_W-1:0] out_count,
	// entry memory
	output logic               mem_we,
	output logic [ADDR_W-1:0]  mem_waddr,
	output rvs_entry_t         mem_wdata,
	output logic               mem_re,
	output logic [ADDR_W-1:0]  mem_raddr,
	input  rvs_entry_t         mem_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	logic [1:0]        state_q;
	logic              op_q;
	logic [DEV_W-1:0]  dev_q;
	logic [REG_W-1:0]  reg_q;
	logic [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [ADDR_W-1:0] pidx_q;
	logic              cmp_vld_q;

	logic [1:0]        res_status_q;
	logic [DEV_W-1:0]  res_dev_q;
	logic [REG_W-1:0]  res_reg_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [CNT_W-1:0]  res_cnt_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [DEV_W-1:0]  out_dev_q;
	logic [REG_W-1:0]  out_reg_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	logic hit;
	logic more;
	logic done;
	logic full;
	logic scan_end;
	logic do_write;
	logic do_insert;
	logic out_free;

	// Shared key comparator on the entry read last cycle
	assign hit  = cmp_vld_q && (mem_rdata.dev_id == dev_q) && (mem_rdata.reg_id == reg_q);
	assign more = (idx_q < cnt_q);
	assign done = hit || !more;
	assign full = (cnt_q == FULL_CNT);

	assign scan_end  = (state_q == S_SCAN) && done;
	assign do_write  = scan_end && (op_q == OP_WRITE) && (hit || !full);
	assign do_insert = do_write && !hit;
	assign out_free  = !out_valid_q || out_ready;

	// Memory access
	assign mem_re      = (state_q == S_SCAN) && !hit && more;
	assign mem_raddr   = idx_q[ADDR_W-1:0];
	assign mem_we      = do_write;
	assign mem_waddr   = hit ? pidx_q : cnt_q[ADDR_W-1:0];
	assign mem_wdata   = '{dev_id: dev_q, reg_id: reg_q, value: val_q};

	assign in_ready = (state_q == S_IDLE);

	// Sequencer and scan pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q     <= '0;
					cmp_vld_q <= 1'b0;
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (done) begin
						cmp_vld_q <= 1'b0;
						state_q   <= S_OUT;
						if (do_insert) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end else begin
						idx_q     <= idx_q + CNT_W'(1);
						cmp_vld_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture request and track the address of the entry in flight
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_q  <= in_op;
			dev_q <= in_dev;
			reg_q <= in_reg;
			val_q <= in_val;
		end
		if (mem_re) begin
			pidx_q <= idx_q[ADDR_W-1:0];
		end
	end

	// Build the result at the end of the scan
	always_ff @(posedge clk) begin
		if (scan_end) begin
			res_cnt_q <= do_insert ? cnt_q + CNT_W'(1) : cnt_q;
			if (op_q == OP_READ) begin
				if (hit) begin
					res_status_q <= STAT_OK;
					res_dev_q    <= mem_rdata.dev_id;
					res_reg_q    <= mem_rdata.reg_id;
					res_val_q    <= mem_rdata.value;
				end else begin
					res_status_q <= STAT_NOT_FOUND;
					res_dev_q    <= '0;
					res_reg_q    <= '0;
					res_val_q    <= '0;
				end
			end else if (do_write) begin
				res_status_q <= STAT_OK;
				res_dev_q    <= dev_q;
				res_reg_q    <= reg_q;
				res_val_q    <= val_q;
			end else begin
				res_status_q <= STAT_FULL;
				res_dev_q    <= '0;
				res_reg_q    <= '0;
				res_val_q    <= '0;
			end
		end
	end

	// Output register: drop on take, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_dev_q    <= res_dev_q;
			out_reg_q    <= res_reg_q;
			out_val_q    <= res_val_q;
			out_cnt_q    <= res_cnt_q;
		end
	end

	// Count reported modulo the field width
	assign cnt_ext = {{COUNT_W{1'b0}}, out_cnt_q};

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_dev    = out_dev_q;
	assign out_reg    = out_reg_q;
	assign out_val    = out_val_q;
	assign out_count  = cnt_ext[COUNT_W-1:0];

endmodule

// File: hw/rtl/register_value_store_top.sv
// Register value store: keyed table of 16-bit values with read and write requests.
//
// Usage:
//   Requests enter on the s_axis channel. s_axis_tuser selects read (0) or
//   write (1); s_axis_tdata carries device number, register number and value.
//   Every request gives exactly one result on the m_axis channel with a status
//   in m_axis_tuser and the entry plus the stored-entry count in m_axis_tdata.
//   Entries are never removed; a write of a new key fills the next free slot,
//   and a write of a new key to a full table reports table full.
// Timing:
//   The block takes one request at a time. A request scans the stored entries
//   through one memory read port and one key comparator, one entry a cycle;
//   a hit ends the scan early. s_axis_tready is low from acceptance until the
//   result is loaded, so the next request is taken only after that load.
// Reset and stall:
//   arst_n empties the table. A result waits in the output register while the
//   receiver holds m_axis_tready low; the next request may be taken and
//   scanned, and its result is held until the register frees up.
module register_value_store_top
	import rvs_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // device_id[15:0], reg_id[23:16], write_value[39:24]
	input  logic        s_axis_tuser,  // op[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_device_id[15:0], out_reg_id[23:16],
	                                   // out_value[39:24], entry_count[44:40], zero[47:45]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	rvs_entry_t         mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	rvs_entry_t         mem_rdata;

	logic [DEV_W-1:0]   res_dev;
	logic [REG_W-1:0]   res_reg;
	logic [VAL_W-1:0]   res_val;
	logic [COUNT_W-1:0] res_count;

	rvs_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_dev     (s_axis_tdata[15:0]),
		.in_reg     (s_axis_tdata[23:16]),
		.in_val     (s_axis_tdata[39:24]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_dev    (res_dev),
		.out_reg    (res_reg),
		.out_val    (res_val),
		.out_count  (res_count),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	rvs_store #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Pack the result fields, padded to whole bytes
	assign m_axis_tdata = {3'b000, res_count, res_val, res_reg, res_dev};

endmodule

// File: bench/testbench.sv
// Testbench for the register value store: directed and random requests checked against a model.
`timescale 1ns / 1ps

module testbench;
	import rvs_pkg::*;

	localparam int TABLE_ENTRIES = 16;
	localparam int KEY_POOL_MAX  = 24;
	localparam int PHASE_ITEMS   = 370;
	localparam int HOLD_CYCLES   = 300;
	localparam int WATCHDOG_MAX  = 4000;
	localparam int TAIL_CYCLES   = 50;
	localparam int MAX_REPORTS   = 200;

	// One request as it travels on the input side
	typedef struct packed {
		logic             op;
		logic [DEV_W-1:0] dev_id;
		logic [REG_W-1:0] reg_num;
		logic [VAL_W-1:0] wr_value;
	} store_cmd_t;

	// One result, in the order tuser then tdata from the low field up
	typedef struct packed {
		logic [1:0]         status;
		logic [DEV_W-1:0]   dev_id;
		logic [REG_W-1:0]   reg_num;
		logic [VAL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [2:0]         pad;
	} store_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        m_tready = 1'b0;
	store_cmd_t  cur_cmd = '0;
	logic        req_taken = 1'b0;
	logic        hold_go = 1'b0;
	int          hold_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          idle_cycles = 0;
	int          issued = 0;
	int          results_seen = 0;
	int          errors = 0;

	wire         s_axis_tready;
	wire         m_axis_tvalid;
	wire [47:0]  m_axis_tdata;
	wire [1:0]   m_axis_tuser;

	store_cmd_t    cmds_to_send[$];
	store_result_t replies_due[$];
	logic [23:0]   key_pool[$];

	// Model copy of the table
	rvs_entry_t         slot_entry[TABLE_ENTRIES];
	logic               slot_used[TABLE_ENTRIES];
	logic [COUNT_W-1:0] stored_count = '0;

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			slot_entry[i] = '0;
			slot_used[i] = 1'b0;
		end
	end

	register_value_store_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata ({cur_cmd.wr_value, cur_cmd.reg_num, cur_cmd.dev_id}),
		.s_axis_tuser (cur_cmd.op),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one request to the model table and return the result it should give
	function automatic store_result_t predict_store(store_cmd_t c);
		int            hit;
		int            free_idx;
		store_result_t r;
		hit = -1;
		free_idx = -1;
		r = '0;
		r.status = STAT_OK;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit < 0 && slot_used[i] && slot_entry[i].dev_id == c.dev_id &&
			    slot_entry[i].reg_id == c.reg_num)
				hit = i;
		end
		if (c.op == OP_READ) begin
			if (hit >= 0) begin
				r.dev_id  = slot_entry[hit].dev_id;
				r.reg_num = slot_entry[hit].reg_id;
				r.value   = slot_entry[hit].value;
			end else begin
				r.status = STAT_NOT_FOUND;
			end
		end else begin
			// new key: take the lowest free slot
			if (hit < 0) begin
				for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
					if (!slot_used[i])
						free_idx = i;
				end
				if (free_idx >= 0) begin
					slot_used[free_idx] = 1'b1;
					stored_count = stored_count + 1'b1;
					hit = free_idx;
				end
			end
			if (hit >= 0) begin
				slot_entry[hit] = '{c.dev_id, c.reg_num, c.wr_value};
				r.dev_id  = c.dev_id;
				r.reg_num = c.reg_num;
				r.value   = c.wr_value;
			end else begin
				r.status = STAT_FULL;
			end
		end
		r.count = stored_count;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endtask

	// Present the next request, or idle, once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (cmds_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_cmd <= cmds_to_send.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Drive ready: one long hold-off when asked, random stalls otherwise
	always @(negedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check results and record accepted requests
	always @(posedge clk) begin
		store_result_t got;
		store_result_t want;
		if (arst_n) begin
			req_taken <= s_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_tready) begin
				got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16],
				       m_axis_tdata[39:24], m_axis_tdata[44:40], m_axis_tdata[47:45]};
				results_seen++;
				if (replies_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t ns: unexpected result, expected none, got 0x%0h",
						         $time, got);
				end else begin
					want = replies_due.pop_front();
					check_field("status", want.status, got.status);
					check_field("out_device_id", want.dev_id, got.dev_id);
					check_field("out_reg_id", want.reg_num, got.reg_num);
					check_field("out_value", want.value, got.value);
					check_field("entry_count", want.count, got.count);
					check_field("tdata padding", want.pad, got.pad);
				end
			end
			if (s_tvalid && s_axis_tready)
				replies_due.push_back(predict_store(cur_cmd));
		end
	end

	// End the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_MAX) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic queue_cmd(logic op, logic [DEV_W-1:0] dev, logic [REG_W-1:0] rnum,
	                         logic [VAL_W-1:0] val);
		store_cmd_t c;
		logic       known;
		c = {op, dev, rnum, val};
		known = 1'b0;
		cmds_to_send.push_back(c);
		issued++;
		foreach (key_pool[i]) begin
			if (key_pool[i] == {dev, rnum})
				known = 1'b1;
		end
		// remember written keys so later requests hit them
		if (op == OP_WRITE && !known && key_pool.size() < KEY_POOL_MAX)
			key_pool.push_back({dev, rnum});
	endtask

	// Mostly known keys, then near misses, fresh keys and extreme keys
	task automatic queue_random_cmd();
		logic [23:0]      key;
		logic [VAL_W-1:0] val;
		logic             op;
		logic             dev_hi;
		logic             reg_hi;
		logic [4:0]       flip;
		int unsigned      pick;
		op = 1'($urandom_range(1));
		pick = $urandom_range(99);
		dev_hi = 1'($urandom_range(1));
		reg_hi = 1'($urandom_range(1));
		if (pick < 55 && key_pool.size() != 0) begin
			key = key_pool[$urandom_range(key_pool.size() - 1)];
		end else if (pick < 70 && key_pool.size() != 0) begin
			key = key_pool[$urandom_range(key_pool.size() - 1)];
			flip = 5'($urandom_range(23));
			key[flip] ^= 1'b1;
		end else if (pick < 85) begin
			key = 24'($urandom);
		end else begin
			key = {{16{dev_hi}}, {8{reg_hi}}};
		end
		if ($urandom_range(9) == 0)
			val = {16{dev_hi}};
		else
			val = 16'($urandom);
		queue_cmd(op, key[23:8], key[7:0], val);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (results_seen != issued);
		@(posedge clk);
	endtask

	task automatic run_phase(int send_pct, int recv_pct, logic with_hold);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			while (cmds_to_send.size() >= 4)
				@(posedge clk);
			if (with_hold && n == 40)
				hold_go = 1'b1;
			queue_random_cmd();
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// reads of an empty table, extreme keys, overwrite, near misses
		queue_cmd(OP_READ, 16'h0000, 8'h00, 16'hffff);
		queue_cmd(OP_READ, 16'hffff, 8'hff, 16'h0000);
		queue_cmd(OP_WRITE, 16'h0000, 8'h00, 16'h0000);
		queue_cmd(OP_WRITE, 16'hffff, 8'hff, 16'hffff);
		queue_cmd(OP_READ, 16'h0000, 8'h00, 16'hffff);
		queue_cmd(OP_READ, 16'hffff, 8'hff, 16'h0000);
		queue_cmd(OP_WRITE, 16'hffff, 8'hff, 16'h1234);
		queue_cmd(OP_READ, 16'hffff, 8'hff, 16'hffff);
		queue_cmd(OP_READ, 16'hffff, 8'h00, 16'h0000);
		queue_cmd(OP_READ, 16'h0000, 8'hff, 16'h0000);
		// fill the table, then insert into a full one
		for (int i = 0; i < TABLE_ENTRIES - 2; i++)
			queue_cmd(OP_WRITE, 16'(16'h1000 + i), 8'(8'h80 + i), 16'(16'ha5a0 ^ i));
		queue_cmd(OP_WRITE, 16'h5555, 8'h55, 16'haaaa);
		queue_cmd(OP_READ, 16'h5555, 8'h55, 16'h0000);
		queue_cmd(OP_READ, 16'(16'h1000 + TABLE_ENTRIES - 3), 8'(8'h80 + TABLE_ENTRIES - 3),
		          16'h0000);
		wait_drained();

		run_phase(0, 0, 1'b1);
		run_phase(82, 0, 1'b0);
		run_phase(0, 82, 1'b0);
		run_phase(20, 20, 1'b0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (replies_due.size() != 0) begin
			errors++;
			$display("%0t ns: results missing, expected %0d more, got 0",
			         $time, replies_due.size());
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rvs_pkg.sv
hw/rtl/rvs_store.sv
hw/rtl/rvs_ctrl.sv
hw/rtl/register_value_store_top.sv
bench/testbench.sv
